@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication property checked on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

@@ design/utrb_pkg.sv @@
// Shared types and constants for the UART TX/RX ring buffer core.
// No dependencies; used by every module of the core.
package utrb_pkg;

  // Buffer geometry
  localparam int TX_DEPTH = 64;
  localparam int RX_DEPTH = 64;
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_CW    = $clog2(TX_DEPTH + 1);
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);
  localparam int LEVEL_W  = 7;

  // Operation codes
  localparam logic [2:0] OP_TX_PUSH    = 3'd0;
  localparam logic [2:0] OP_TX_POP     = 3'd1;
  localparam logic [2:0] OP_RX_PUT     = 3'd2;
  localparam logic [2:0] OP_RX_GET     = 3'd3;
  localparam logic [2:0] OP_TX_DISCARD = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_RETRY    = 2'd2;

  // Value returned by a read of an empty RX buffer
  localparam logic [7:0] RX_EMPTY_BYTE = 8'hFF;

  // Register byte addresses
  localparam int          PADDR_W          = 3;
  localparam logic [PADDR_W-1:0] REG_TX_MODE = 3'd0;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_in;
  } item_t;

  typedef struct packed {
    logic [7:0]         data_out;
    logic               data_valid;
    logic [1:0]         status;
    logic               wake;
    logic [LEVEL_W-1:0] tx_level;
    logic [LEVEL_W-1:0] rx_level;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted item
    logic exec;     // update pointers, access memories, latch result
  } dp_cmd_t;

endpackage

@@ design/uart_tx_rx_ring_buffers_core.sv @@
// Top level of the UART TX/RX ring buffer core.
// Depends on utrb_pkg, utrb_regs, utrb_ctrl, utrb_dpath and assert_macros.svh.

// A command is taken when start is high and busy is low. The execute state that
// follows updates the head/count registers and makes at most one access to the
// TX or RX memory port (reads are registered); the cycle after that shows the
// result with done high for exactly that one cycle. busy stays high through the
// execute and done states, so a new command is taken only once the previous one
// has finished. The receiver cannot stall: sample result whenever done is high.
// tx_level and rx_level always show the current fill levels.
// Buffer contents are not cleared by reset; head and count registers are.
`include "assert_macros.svh"

module uart_tx_rx_ring_buffers_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  utrb_pkg::item_t              item,
  output logic                         done,
  output utrb_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [utrb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  utrb_pkg::dp_cmd_t cmd;
  logic              tx_block_mode;

  // Configuration registers
  utrb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .tx_block_mode (tx_block_mode)
  );

  // Controller
  utrb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Datapath
  utrb_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .item          (item),
    .tx_block_mode (tx_block_mode),
    .result        (result)
  );

  // Checks
  `ASSERT_PROP(a_done_two_after_accept, clk, rst, (start && !busy) |=> ##1 done)
  `ASSERT_PROP(a_done_while_busy, clk, rst, done |-> busy)
  `ASSERT_NEVER(a_tx_level_range, clk, rst, result.tx_level > 7'(utrb_pkg::TX_DEPTH))
  `ASSERT_NEVER(a_rx_level_range, clk, rst, result.rx_level > 7'(utrb_pkg::RX_DEPTH))
  `ASSERT_NEVER(a_valid_with_error, clk, rst, done && result.data_valid && (result.status != utrb_pkg::ST_OK))

endmodule

@@ design/utrb_regs.sv @@
// APB-style configuration register block (TX block mode).
// Depends on utrb_pkg.
module utrb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [utrb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic                         tx_block_mode
);

  logic wr_en;
  logic sel_mode;

  // Register decode on the word address
  assign sel_mode = (paddr[utrb_pkg::PADDR_W-1:2] == utrb_pkg::REG_TX_MODE[utrb_pkg::PADDR_W-1:2]);
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_block_mode <= 1'b0;
    end else if (wr_en && sel_mode) begin
      tx_block_mode <= pwdata[0];
    end
  end

  // Read back
  always_comb begin
    prdata = 32'd0;
    if (sel_mode) begin
      prdata = {31'd0, tx_block_mode};
    end
  end

endmodule

@@ design/utrb_ctrl.sv @@
// Sequencing controller: accept, execute, present result.
// Depends on utrb_pkg; drives the datapath through dp_cmd_t.
module utrb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output utrb_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC:  state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  assign busy        = (state != S_IDLE);
  assign done        = (state == S_DONE);
  assign cmd.capture = (state == S_IDLE) && start;
  assign cmd.exec    = (state == S_EXEC);

endmodule

@@ design/utrb_dpath.sv @@
// Datapath: TX and RX byte memories, head/count registers, result registers.
// Depends on utrb_pkg; steered by utrb_ctrl commands.
module utrb_dpath (
  input  logic                clk,
  input  logic                rst,
  input  utrb_pkg::dp_cmd_t   cmd,
  input  utrb_pkg::item_t     item,
  input  logic                tx_block_mode,
  output utrb_pkg::result_t   result
);

  typedef enum logic [1:0] {
    SRC_CONST = 2'b00,
    SRC_TX    = 2'b01,
    SRC_RX    = 2'b10
  } src_t;

  // Latched item
  logic [2:0] op;
  logic [7:0] byte_in;

  // Pointer state
  logic [utrb_pkg::TX_AW-1:0] tx_head;
  logic [utrb_pkg::TX_AW-1:0] tx_head_next;
  logic [utrb_pkg::TX_CW-1:0] tx_count;
  logic [utrb_pkg::TX_CW-1:0] tx_count_next;
  logic [utrb_pkg::RX_AW-1:0] rx_head;
  logic [utrb_pkg::RX_AW-1:0] rx_head_next;
  logic [utrb_pkg::RX_CW-1:0] rx_count;
  logic [utrb_pkg::RX_CW-1:0] rx_count_next;

  // Memories
  logic [7:0] tx_mem [utrb_pkg::TX_DEPTH];
  logic [7:0] rx_mem [utrb_pkg::RX_DEPTH];
  logic [7:0] tx_rdata;
  logic [7:0] rx_rdata;
  logic       tx_we;
  logic       rx_we;
  logic       tx_re;
  logic       rx_re;
  logic [utrb_pkg::TX_AW-1:0] tx_waddr;
  logic [utrb_pkg::RX_AW-1:0] rx_waddr;

  // Result registers
  src_t       src;
  src_t       src_next;
  logic [7:0] const_data;
  logic [7:0] const_data_next;
  logic       valid;
  logic       valid_next;
  logic [1:0] status;
  logic [1:0] status_next;
  logic       wake;
  logic       wake_next;

  // Flags and address arithmetic
  logic                         tx_full;
  logic                         tx_empty;
  logic                         rx_full;
  logic                         rx_empty;
  logic [utrb_pkg::TX_CW:0]     tx_sum;
  logic [utrb_pkg::RX_CW:0]     rx_sum;
  logic [utrb_pkg::TX_AW-1:0]   tx_head_inc;
  logic [utrb_pkg::RX_AW-1:0]   rx_head_inc;

  assign tx_full  = (tx_count == utrb_pkg::TX_CW'(utrb_pkg::TX_DEPTH));
  assign tx_empty = (tx_count == '0);
  assign rx_full  = (rx_count == utrb_pkg::RX_CW'(utrb_pkg::RX_DEPTH));
  assign rx_empty = (rx_count == '0);

  // Tail = head + count, wrapped with one compare and subtract
  assign tx_sum = (utrb_pkg::TX_CW+1)'(tx_head) + (utrb_pkg::TX_CW+1)'(tx_count);
  assign rx_sum = (utrb_pkg::RX_CW+1)'(rx_head) + (utrb_pkg::RX_CW+1)'(rx_count);

  always_comb begin
    if (tx_sum >= (utrb_pkg::TX_CW+1)'(utrb_pkg::TX_DEPTH)) begin
      tx_waddr = utrb_pkg::TX_AW'(tx_sum - (utrb_pkg::TX_CW+1)'(utrb_pkg::TX_DEPTH));
    end else begin
      tx_waddr = utrb_pkg::TX_AW'(tx_sum);
    end
    // a full RX buffer overwrites the oldest byte at the head
    if (rx_full) begin
      rx_waddr = rx_head;
    end else if (rx_sum >= (utrb_pkg::RX_CW+1)'(utrb_pkg::RX_DEPTH)) begin
      rx_waddr = utrb_pkg::RX_AW'(rx_sum - (utrb_pkg::RX_CW+1)'(utrb_pkg::RX_DEPTH));
    end else begin
      rx_waddr = utrb_pkg::RX_AW'(rx_sum);
    end
  end

  assign tx_head_inc = (tx_head == utrb_pkg::TX_AW'(utrb_pkg::TX_DEPTH - 1)) ?
                       '0 : tx_head + utrb_pkg::TX_AW'(1);
  assign rx_head_inc = (rx_head == utrb_pkg::RX_AW'(utrb_pkg::RX_DEPTH - 1)) ?
                       '0 : rx_head + utrb_pkg::RX_AW'(1);

  // Operation decode
  always_comb begin
    tx_head_next    = tx_head;
    tx_count_next   = tx_count;
    rx_head_next    = rx_head;
    rx_count_next   = rx_count;
    tx_we           = 1'b0;
    rx_we           = 1'b0;
    tx_re           = 1'b0;
    rx_re           = 1'b0;
    src_next        = SRC_CONST;
    const_data_next = 8'd0;
    valid_next      = 1'b0;
    status_next     = utrb_pkg::ST_OK;
    wake_next       = 1'b0;
    unique case (op)
      utrb_pkg::OP_TX_PUSH: begin
        if (tx_full) begin
          status_next = tx_block_mode ? utrb_pkg::ST_RETRY : utrb_pkg::ST_OVERFLOW;
        end else begin
          tx_we         = 1'b1;
          tx_count_next = tx_count + utrb_pkg::TX_CW'(1);
        end
      end
      utrb_pkg::OP_TX_POP: begin
        if (!tx_empty) begin
          wake_next     = tx_block_mode && tx_full;
          tx_re         = 1'b1;
          src_next      = SRC_TX;
          valid_next    = 1'b1;
          tx_head_next  = tx_head_inc;
          tx_count_next = tx_count - utrb_pkg::TX_CW'(1);
        end
      end
      utrb_pkg::OP_RX_PUT: begin
        rx_we = 1'b1;
        if (rx_full) begin
          rx_head_next = rx_head_inc;
        end else begin
          rx_count_next = rx_count + utrb_pkg::RX_CW'(1);
        end
      end
      utrb_pkg::OP_RX_GET: begin
        if (rx_empty) begin
          const_data_next = utrb_pkg::RX_EMPTY_BYTE;
        end else begin
          rx_re         = 1'b1;
          src_next      = SRC_RX;
          valid_next    = 1'b1;
          rx_head_next  = rx_head_inc;
          rx_count_next = rx_count - utrb_pkg::RX_CW'(1);
        end
      end
      utrb_pkg::OP_TX_DISCARD: begin
        tx_head_next  = '0;
        tx_count_next = '0;
      end
      default: begin
        // unused codes leave pointers and memories alone
      end
    endcase
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= item.operation;
      byte_in <= item.data_in;
    end
  end

  // Pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head  <= '0;
      tx_count <= '0;
      rx_head  <= '0;
      rx_count <= '0;
    end else if (cmd.exec) begin
      tx_head  <= tx_head_next;
      tx_count <= tx_count_next;
      rx_head  <= rx_head_next;
      rx_count <= rx_count_next;
    end
  end

  // TX memory: at most one write or one registered read per execute cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && tx_we) begin
      tx_mem[tx_waddr] <= byte_in;
    end
    if (cmd.exec && tx_re) begin
      tx_rdata <= tx_mem[tx_head];
    end
  end

  // RX memory
  always_ff @(posedge clk) begin
    if (cmd.exec && rx_we) begin
      rx_mem[rx_waddr] <= byte_in;
    end
    if (cmd.exec && rx_re) begin
      rx_rdata <= rx_mem[rx_head];
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      src <= SRC_CONST;
    end else if (cmd.exec) begin
      src <= src_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      const_data <= const_data_next;
      valid      <= valid_next;
      status     <= status_next;
      wake       <= wake_next;
    end
  end

  always_comb begin
    case (src)
      SRC_TX:  result.data_out = tx_rdata;
      SRC_RX:  result.data_out = rx_rdata;
      default: result.data_out = const_data;
    endcase
  end

  assign result.data_valid = valid;
  assign result.status     = status;
  assign result.wake       = wake;
  assign result.tx_level   = utrb_pkg::LEVEL_W'(tx_count);
  assign result.rx_level   = utrb_pkg::LEVEL_W'(rx_count);

endmodule
